### design/cmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cmr_pkg;

  localparam int MAX_NODES  = 1024;
  localparam int MAX_EDGES  = 4096;
  localparam int NODE_W     = 10;
  localparam int NCNT_W     = 11;
  localparam int EDGE_AW    = 12;
  localparam int ECNT_W     = 13;
  localparam int IDX_W      = 11;
  localparam int QUE_DEPTH  = MAX_EDGES + 1;
  localparam int QUE_AW     = $clog2(QUE_DEPTH);

  localparam logic [IDX_W-1:0] UNASSIGNED = '1;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_CLOSE   = 2'd1,
    CMD_COMPUTE = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NODES     = 2'd1,
    ST_EDGES     = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  localparam logic REG_REVERSE  = 1'b0;
  localparam logic REG_PRESERVE = 1'b1;

  typedef struct packed {
    logic [1:0]        command;
    logic [NODE_W-1:0] neighbour;
    logic [NODE_W-1:0] read_index;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] new_index;
    logic [1:0]       status;
  } rsp_t;

endpackage
`default_nettype wire

### design/cuthill_mckee_reorder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Cuthill-McKee reordering unit.
// The req channel carries commands: add a neighbour to the open row, close the
// row, compute the ordering, or read one entry of the new index table. The rsp
// channel returns one beat for compute, for read, and for a rejected load.
// Load beats are taken one per cycle unless rsp_stall holds a response, and
// give no response unless rejected. A read passes S_RD_A and S_RD_B before
// its response is registered. A compute holds req_stall high while the
// sequencer runs over the memories: a range check over the closed rows' edges,
// clearing the visited flags, a scan of the nodes per distinct degree to pick
// walk roots, walks over each row per distinct degree in it, and the table
// build. Every step is one access to the block memories, which sets the pace.
// The cfg channel is always ready and writes reverse_order (index 0) or
// preserve_consecutive (index 1); write it only while the unit is idle.
// Reset empties the graph, clears both registers and makes every table entry
// read as unassigned; no clearing pass is needed. While rsp_stall holds a
// response, no new request is taken.
module cuthill_mckee_reorder_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire cmr_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output cmr_pkg::rsp_t      rsp,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic          cfg_index,
  input  wire logic          cfg_data
);
  import cmr_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_RD_A, S_RD_B, S_CHK_A, S_CHK_B, S_CLR, S_SCAN_A, S_SCAN_B,
    S_POP_A, S_POP_B, S_POP_C, S_EXP_A, S_EXP_B, S_EXP_C,
    S_PL_A, S_PL_B, S_ISO_A, S_ISO_B, S_CS_A, S_CS_B, S_FL_A, S_FL_B, S_DONE
  } state_t;

  state_t            state;
  logic              rev, pc;
  logic [NCNT_W-1:0] node_count, tn, i, len, pos;
  logic [ECNT_W-1:0] edge_count, row_begin, k, lo, hi;
  logic [ECNT_W-1:0] cur_d, nxt_d, ecur, enxt;
  logic              have_nxt, ehave, table_ok;
  logic [QUE_AW-1:0] head, tail;
  logic [NODE_W-1:0] f, nb, rd;
  logic [IDX_W-1:0]  prev;

  logic              nbr_we, deg_we, rs_we, hnd_we, que_we, vis_we, tbl_we;
  logic [EDGE_AW-1:0] nbr_waddr, nbr_raddr;
  logic [NODE_W-1:0] nbr_wdata, nbr_rdata;
  logic [NODE_W-1:0] deg_waddr, deg_raddr, rs_waddr, rs_raddr, hnd_waddr, hnd_raddr;
  logic [ECNT_W-1:0] deg_wdata, deg_rdata, rs_wdata, rs_rdata;
  logic              hnd_wdata, hnd_rdata;
  logic [QUE_AW-1:0] que_waddr, que_raddr;
  logic [NODE_W-1:0] que_wdata, que_rdata;
  logic [NODE_W-1:0] vis_waddr, vis_raddr, vis_wdata, vis_rdata;
  logic [NODE_W-1:0] tbl_waddr, tbl_raddr;
  logic [IDX_W-1:0]  tbl_wdata, tbl_rdata;

  logic              accept, node_full, edge_full;
  logic              s_start, s_upd, e_match, e_upd;
  logic [NCNT_W-1:0] rev_i, rev_pos;
  logic [IDX_W-1:0]  fill_val;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign node_full = (node_count == NCNT_W'(MAX_NODES));
  assign edge_full = (edge_count == ECNT_W'(MAX_EDGES));

  // Both walk-root selection and neighbour expansion go through the list one
  // degree level at a time, which gives the stable order by degree. Nodes of
  // degree zero count as already handled.
  assign s_start = (deg_rdata == cur_d) && (deg_rdata != '0) && !hnd_rdata;
  assign s_upd   = (deg_rdata > cur_d) && (!have_nxt || deg_rdata < nxt_d);
  assign e_match = (deg_rdata == ecur) && (deg_rdata != '0) && !hnd_rdata;
  assign e_upd   = (deg_rdata > ecur) && (!ehave || deg_rdata < enxt);
  assign rev_i   = len - NCNT_W'(1) - i;
  assign rev_pos = len - NCNT_W'(1) - pos;
  assign fill_val = (deg_rdata != '0) ? tbl_rdata :
                    ((i == '0) ? UNASSIGNED : IDX_W'(prev + IDX_W'(1)));

  cmr_ram #(.DEPTH(MAX_EDGES), .WIDTH(NODE_W)) u_nbr (
    .clk, .we(nbr_we), .waddr(nbr_waddr), .wdata(nbr_wdata),
    .raddr(nbr_raddr), .rdata(nbr_rdata));
  cmr_ram #(.DEPTH(MAX_NODES), .WIDTH(ECNT_W)) u_deg (
    .clk, .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
    .raddr(deg_raddr), .rdata(deg_rdata));
  cmr_ram #(.DEPTH(MAX_NODES), .WIDTH(ECNT_W)) u_rs (
    .clk, .we(rs_we), .waddr(rs_waddr), .wdata(rs_wdata),
    .raddr(rs_raddr), .rdata(rs_rdata));
  cmr_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_hnd (
    .clk, .we(hnd_we), .waddr(hnd_waddr), .wdata(hnd_wdata),
    .raddr(hnd_raddr), .rdata(hnd_rdata));
  cmr_ram #(.DEPTH(QUE_DEPTH), .WIDTH(NODE_W)) u_que (
    .clk, .we(que_we), .waddr(que_waddr), .wdata(que_wdata),
    .raddr(que_raddr), .rdata(que_rdata));
  cmr_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_vis (
    .clk, .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
    .raddr(vis_raddr), .rdata(vis_rdata));
  cmr_ram #(.DEPTH(MAX_NODES), .WIDTH(IDX_W)) u_tbl (
    .clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata));

  always_comb begin
    nbr_we = 1'b0; nbr_waddr = '0; nbr_wdata = '0; nbr_raddr = '0;
    deg_we = 1'b0; deg_waddr = '0; deg_wdata = '0; deg_raddr = '0;
    rs_we  = 1'b0; rs_waddr  = '0; rs_wdata  = '0; rs_raddr  = '0;
    hnd_we = 1'b0; hnd_waddr = '0; hnd_wdata = 1'b0; hnd_raddr = '0;
    que_we = 1'b0; que_waddr = '0; que_wdata = '0; que_raddr = '0;
    vis_we = 1'b0; vis_waddr = '0; vis_wdata = '0; vis_raddr = '0;
    tbl_we = 1'b0; tbl_waddr = '0; tbl_wdata = '0; tbl_raddr = '0;
    case (state)
      S_IDLE: begin
        if (accept && !node_full) begin
          if (req.command == CMD_ADD && !edge_full) begin
            nbr_we    = 1'b1;
            nbr_waddr = edge_count[EDGE_AW-1:0];
            nbr_wdata = req.neighbour;
          end else if (req.command == CMD_CLOSE) begin
            deg_we    = 1'b1;
            deg_waddr = node_count[NODE_W-1:0];
            deg_wdata = edge_count - row_begin;
            rs_we     = 1'b1;
            rs_waddr  = node_count[NODE_W-1:0];
            rs_wdata  = row_begin;
          end
        end
      end
      S_RD_A:  tbl_raddr = rd;
      S_CHK_A: nbr_raddr = k[EDGE_AW-1:0];
      S_CLR: begin
        hnd_we    = (i != node_count);
        hnd_waddr = i[NODE_W-1:0];
      end
      S_SCAN_A: begin
        deg_raddr = i[NODE_W-1:0];
        hnd_raddr = i[NODE_W-1:0];
      end
      S_SCAN_B: begin
        que_we    = 1'b1;
        que_wdata = i[NODE_W-1:0];
      end
      S_POP_A: que_raddr = head;
      S_POP_B: begin
        hnd_raddr = que_rdata;
        rs_raddr  = que_rdata;
        deg_raddr = que_rdata;
      end
      S_POP_C: begin
        if (!hnd_rdata) begin
          hnd_we    = 1'b1;
          hnd_waddr = f;
          hnd_wdata = 1'b1;
          vis_we    = 1'b1;
          vis_waddr = len[NODE_W-1:0];
          vis_wdata = f;
        end
      end
      S_EXP_A: nbr_raddr = k[EDGE_AW-1:0];
      S_EXP_B: begin
        deg_raddr = nbr_rdata;
        hnd_raddr = nbr_rdata;
      end
      S_EXP_C: begin
        que_we    = e_match;
        que_waddr = tail;
        que_wdata = nb;
      end
      S_PL_A: vis_raddr = rev ? rev_i[NODE_W-1:0] : i[NODE_W-1:0];
      S_PL_B: begin
        tbl_we    = 1'b1;
        tbl_waddr = vis_rdata;
        tbl_wdata = i;
      end
      S_ISO_A: deg_raddr = i[NODE_W-1:0];
      S_ISO_B: begin
        tbl_we    = (deg_rdata == '0);
        tbl_waddr = i[NODE_W-1:0];
        tbl_wdata = pos;
      end
      S_CS_A: begin
        deg_raddr = i[NODE_W-1:0];
        vis_raddr = rev ? rev_pos[NODE_W-1:0] : pos[NODE_W-1:0];
      end
      S_CS_B: begin
        tbl_we    = (deg_rdata != '0);
        tbl_waddr = vis_rdata;
        tbl_wdata = i;
      end
      S_FL_A: begin
        deg_raddr = i[NODE_W-1:0];
        tbl_raddr = i[NODE_W-1:0];
      end
      S_FL_B: begin
        tbl_we    = 1'b1;
        tbl_waddr = i[NODE_W-1:0];
        tbl_wdata = fill_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      rev        <= 1'b0;
      pc         <= 1'b0;
      node_count <= '0;
      edge_count <= '0;
      row_begin  <= '0;
      table_ok   <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_REVERSE) begin
          rev <= cfg_data;
        end else if (cfg_index == REG_PRESERVE) begin
          pc <= cfg_data;
        end
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            rd <= req.read_index;
            case (req.command)
              CMD_ADD, CMD_CLOSE: begin
                if (node_full) begin
                  rsp_valid <= 1'b1;
                  rsp       <= '{new_index: UNASSIGNED, status: ST_NODES};
                end else if (req.command == CMD_ADD) begin
                  if (edge_full) begin
                    rsp_valid <= 1'b1;
                    rsp       <= '{new_index: UNASSIGNED, status: ST_EDGES};
                  end else begin
                    edge_count <= edge_count + ECNT_W'(1);
                  end
                end else begin
                  node_count <= node_count + NCNT_W'(1);
                  row_begin  <= edge_count;
                end
              end
              CMD_COMPUTE: begin
                k     <= '0;
                len   <= '0;
                state <= S_CHK_A;
              end
              default: state <= S_RD_A;
            endcase
          end
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: begin
          rsp_valid <= 1'b1;
          rsp.status <= ST_OK;
          rsp.new_index <= (table_ok && ({1'b0, rd} < tn)) ? tbl_rdata : UNASSIGNED;
          state <= S_IDLE;
        end
        S_CHK_A: begin
          if (k == row_begin) begin
            i     <= '0;
            state <= S_CLR;
          end else begin
            state <= S_CHK_B;
          end
        end
        S_CHK_B: begin
          if ({1'b0, nbr_rdata} >= node_count) begin
            table_ok  <= 1'b0;
            rsp_valid <= 1'b1;
            rsp       <= '{new_index: UNASSIGNED, status: ST_RANGE};
            state     <= S_IDLE;
          end else begin
            k     <= k + ECNT_W'(1);
            state <= S_CHK_A;
          end
        end
        S_CLR: begin
          if (i == node_count) begin
            i        <= '0;
            cur_d    <= '0;
            have_nxt <= 1'b0;
            state    <= S_SCAN_A;
          end else begin
            i <= i + NCNT_W'(1);
          end
        end
        S_SCAN_A: begin
          if (i == node_count) begin
            if (have_nxt) begin
              cur_d    <= nxt_d;
              have_nxt <= 1'b0;
              i        <= '0;
            end else begin
              i     <= '0;
              pos   <= '0;
              state <= pc ? S_CS_A : S_PL_A;
            end
          end else begin
            state <= S_SCAN_B;
          end
        end
        S_SCAN_B: begin
          i <= i + NCNT_W'(1);
          if (s_start) begin
            head  <= '0;
            tail  <= QUE_AW'(1);
            state <= S_POP_A;
          end else begin
            if (s_upd) begin
              nxt_d    <= deg_rdata;
              have_nxt <= 1'b1;
            end
            state <= S_SCAN_A;
          end
        end
        S_POP_A: begin
          if (head == tail) begin
            state <= S_SCAN_A;
          end else begin
            head  <= head + QUE_AW'(1);
            state <= S_POP_B;
          end
        end
        S_POP_B: begin
          f     <= que_rdata;
          state <= S_POP_C;
        end
        S_POP_C: begin
          if (hnd_rdata) begin
            state <= S_POP_A;
          end else begin
            len   <= len + NCNT_W'(1);
            k     <= rs_rdata;
            lo    <= rs_rdata;
            hi    <= rs_rdata + deg_rdata;
            ecur  <= '0;
            ehave <= 1'b0;
            state <= S_EXP_A;
          end
        end
        S_EXP_A: begin
          if (k == hi) begin
            if (ehave) begin
              ecur  <= enxt;
              ehave <= 1'b0;
              k     <= lo;
            end else begin
              state <= S_POP_A;
            end
          end else begin
            state <= S_EXP_B;
          end
        end
        S_EXP_B: begin
          nb    <= nbr_rdata;
          state <= S_EXP_C;
        end
        S_EXP_C: begin
          if (e_match) begin
            tail <= tail + QUE_AW'(1);
          end else if (e_upd) begin
            enxt  <= deg_rdata;
            ehave <= 1'b1;
          end
          k     <= k + ECNT_W'(1);
          state <= S_EXP_A;
        end
        S_PL_A: begin
          if (i == len) begin
            i     <= '0;
            pos   <= len;
            state <= S_ISO_A;
          end else begin
            state <= S_PL_B;
          end
        end
        S_PL_B: begin
          i     <= i + NCNT_W'(1);
          state <= S_PL_A;
        end
        S_ISO_A: state <= (i == node_count) ? S_DONE : S_ISO_B;
        S_ISO_B: begin
          if (deg_rdata == '0) begin
            pos <= pos + NCNT_W'(1);
          end
          i     <= i + NCNT_W'(1);
          state <= S_ISO_A;
        end
        S_CS_A: begin
          if (i == node_count) begin
            i     <= '0;
            state <= S_FL_A;
          end else begin
            state <= S_CS_B;
          end
        end
        S_CS_B: begin
          if (deg_rdata != '0) begin
            pos <= pos + NCNT_W'(1);
          end
          i     <= i + NCNT_W'(1);
          state <= S_CS_A;
        end
        S_FL_A: state <= (i == node_count) ? S_DONE : S_FL_B;
        S_FL_B: begin
          prev  <= fill_val;
          i     <= i + NCNT_W'(1);
          state <= S_FL_A;
        end
        S_DONE: begin
          table_ok  <= 1'b1;
          tn        <= node_count;
          rsp_valid <= 1'b1;
          rsp       <= '{new_index: UNASSIGNED, status: ST_OK};
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/cmr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module cmr_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### verif/cuthill_mckee_reorder_unit_tb.sv
`timescale 1ns / 1ps
module cuthill_mckee_reorder_unit_tb;
  import cmr_pkg::*;

  localparam int CYCLE_LIMIT = 6000000;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_stall;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_stall = 1'b0;
  rsp_t  rsp;
  logic  cfg_valid = 1'b0;
  logic  cfg_ready;
  logic  cfg_index = 1'b0;
  logic  cfg_data = 1'b0;

  cuthill_mckee_reorder_unit dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the graph, the registers and the new-index table.
  logic [NODE_W-1:0] adj_mem [MAX_EDGES];
  int                row_ptr [MAX_NODES+1];
  int                n_nodes, n_edges;
  logic [IDX_W-1:0]  idx_tab [MAX_NODES];
  logic              rev_mode, cons_mode;
  logic              done_flag [MAX_NODES];
  logic              written [MAX_NODES];
  logic [NODE_W-1:0] by_degree [MAX_NODES];
  logic [NODE_W-1:0] bfs_fifo [MAX_EDGES+1];
  logic [NODE_W-1:0] visited [MAX_NODES];

  req_t  beats_to_send [$];
  rsp_t  expected_rsp [$];
  int    errors, n_results, n_computes, n_reads, cycles;
  int    req_gap, rsp_gap;
  bit    quiet;
  int    plan_nodes, plan_edges, n_items;

  function automatic int degree(int nd);
    return row_ptr[nd+1] - row_ptr[nd];
  endfunction

  function automatic status_t reorder_graph();
    int n, len, first, head, tail, k, j, d, cnt, pos;
    logic [NODE_W-1:0] v, f;
    n = n_nodes;
    len = 0;
    first = 0;
    for (int i = 0; i < MAX_NODES; i++) begin
      idx_tab[i] = UNASSIGNED;
      done_flag[i] = 1'b0;
      written[i] = 1'b0;
    end
    for (k = 0; k < row_ptr[n]; k++)
      if (adj_mem[k] >= n) return ST_RANGE;
    for (int i = 0; i < n; i++) begin
      if (degree(i) == 0) begin
        done_flag[i] = 1'b1;
      end else begin
        for (k = row_ptr[i] + 1; k < row_ptr[i+1]; k++) begin
          v = adj_mem[k];
          d = degree(v);
          j = k;
          while (j > row_ptr[i] && degree(adj_mem[j-1]) > d) begin
            adj_mem[j] = adj_mem[j-1];
            j--;
          end
          adj_mem[j] = v;
        end
      end
    end
    for (k = 0; k < n; k++) by_degree[k] = k[NODE_W-1:0];
    for (k = 1; k < n; k++) begin
      v = by_degree[k];
      d = degree(v);
      j = k;
      while (j > 0 && degree(by_degree[j-1]) > d) begin
        by_degree[j] = by_degree[j-1];
        j--;
      end
      by_degree[j] = v;
    end
    forever begin
      head = 0;
      tail = 0;
      while (first < n && done_flag[by_degree[first]]) first++;
      if (first >= n) break;
      bfs_fifo[tail++] = by_degree[first];
      while (head < tail) begin
        f = bfs_fifo[head++];
        if (done_flag[f]) continue;
        done_flag[f] = 1'b1;
        if (len < MAX_NODES) visited[len++] = f;
        for (k = row_ptr[f]; k < row_ptr[f+1]; k++)
          if (!done_flag[adj_mem[k]] && tail < MAX_EDGES + 1) bfs_fifo[tail++] = adj_mem[k];
      end
    end
    if (cons_mode) begin
      cnt = 0;
      for (int i = 0; i < n; i++) begin
        if (degree(i) == 0 || cnt >= len) continue;
        f = rev_mode ? visited[len-1-cnt] : visited[cnt];
        cnt++;
        idx_tab[f] = i[IDX_W-1:0];
        written[f] = 1'b1;
      end
      for (int i = 1; i < n; i++)
        if (!written[i]) idx_tab[i] = idx_tab[i-1] + 1'b1;
    end else begin
      pos = len;
      for (int i = 0; i < len; i++) begin
        f = rev_mode ? visited[len-1-i] : visited[i];
        idx_tab[f] = i[IDX_W-1:0];
      end
      for (int i = 0; i < n; i++)
        if (degree(i) == 0) begin
          idx_tab[i] = pos[IDX_W-1:0];
          pos++;
        end
    end
    return ST_OK;
  endfunction

  task automatic predict_beat(req_t b);
    rsp_t r;
    r.new_index = UNASSIGNED;
    r.status = ST_OK;
    case (b.command)
      CMD_ADD, CMD_CLOSE: begin
        if (n_nodes >= MAX_NODES) begin
          r.status = ST_NODES;
        end else if (b.command == CMD_ADD && n_edges >= MAX_EDGES) begin
          r.status = ST_EDGES;
        end else if (b.command == CMD_ADD) begin
          adj_mem[n_edges++] = b.neighbour;
        end else begin
          n_nodes++;
          row_ptr[n_nodes] = n_edges;
        end
        if (r.status != ST_OK) expected_rsp = {expected_rsp, r};
      end
      CMD_COMPUTE: begin
        r.status = reorder_graph();
        expected_rsp = {expected_rsp, r};
      end
      default: begin
        r.new_index = idx_tab[b.read_index];
        expected_rsp = {expected_rsp, r};
      end
    endcase
  endtask

  task automatic report(string what, rsp_t got, rsp_t want);
    errors++;
    $display("MISMATCH %s: got index %0d status %0d, want index %0d status %0d",
             what, got.new_index, got.status, want.new_index, want.status);
  endtask

  // Request driver.
  always @(posedge clk) begin
    logic nxt_valid;
    req_t nxt_req;
    nxt_valid = req_valid;
    nxt_req = req;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
    if (!rst) begin
      if (req_valid && !req_stall) begin
        predict_beat(req);
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (req_gap > 0) begin
          req_gap--;
        end else if (beats_to_send.size() > 0) begin
          nxt_req = beats_to_send.pop_front();
          nxt_valid = 1'b1;
          if (!quiet && $urandom_range(0, 19) == 0) req_gap = $urandom_range(1, 16);
        end
      end
    end
    req_valid <= nxt_valid;
    req <= nxt_req;
  end

  // Response monitor and checker.
  always @(posedge clk) begin
    rsp_t want;
    logic nxt_stall;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        n_results++;
        if (expected_rsp.size() == 0) begin
          errors++;
          $display("MISMATCH: response beat with nothing expected");
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.new_index !== want.new_index) report("new_index", rsp, want);
          if (rsp.status !== want.status) report("status", rsp, want);
        end
      end
      nxt_stall = 1'b0;
      if (rsp_gap > 0) begin
        rsp_gap--;
        nxt_stall = 1'b1;
      end else if (!quiet && $urandom_range(0, 15) == 0) begin
        rsp_gap = $urandom_range(0, 15);
        nxt_stall = 1'b1;
      end
      rsp_stall <= nxt_stall;
    end
  end

  task automatic push_beat(cmd_t c, int nb, int rd);
    req_t b;
    b.command = c;
    b.neighbour = nb[NODE_W-1:0];
    b.read_index = rd[NODE_W-1:0];
    beats_to_send = {beats_to_send, b};
    n_items++;
    if (c == CMD_COMPUTE) n_computes++;
    if (c == CMD_READ) n_reads++;
    if (c == CMD_CLOSE && plan_nodes < MAX_NODES) plan_nodes++;
    if (c == CMD_ADD && plan_nodes < MAX_NODES && plan_edges < MAX_EDGES) plan_edges++;
  endtask

  task automatic wait_idle();
    while (!(beats_to_send.size() == 0 && !req_valid && expected_rsp.size() == 0))
      @(posedge clk);
    // Load beats give no response, so let the unit settle.
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_REVERSE) rev_mode = val;
    else cons_mode = val;
  endtask

  task automatic read_burst(int cnt);
    for (int i = 0; i < cnt; i++)
      push_beat(CMD_READ, 0, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023)
                                                          : $urandom_range(0, plan_nodes + 1));
  endtask

  initial begin
    int k;
    for (int i = 0; i <= MAX_NODES; i++) row_ptr[i] = 0;
    for (int i = 0; i < MAX_NODES; i++) idx_tab[i] = UNASSIGNED;
    n_nodes = 0; n_edges = 0; rev_mode = 1'b0; cons_mode = 1'b0;
    errors = 0; n_results = 0; cycles = 0; req_gap = 0; rsp_gap = 0; quiet = 0;
    plan_nodes = 0; plan_edges = 0; n_items = 0; n_computes = 0; n_reads = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Empty graph, then a small graph with an isolated node and an open row.
    push_beat(CMD_COMPUTE, 0, 0);
    push_beat(CMD_READ, 0, 0);
    push_beat(CMD_READ, 0, 1023);
    push_beat(CMD_ADD, 1, 0); push_beat(CMD_ADD, 2, 0); push_beat(CMD_CLOSE, 0, 0);
    push_beat(CMD_ADD, 0, 0); push_beat(CMD_CLOSE, 0, 0);
    push_beat(CMD_ADD, 0, 0); push_beat(CMD_CLOSE, 0, 0);
    push_beat(CMD_CLOSE, 0, 0);
    push_beat(CMD_ADD, 5, 0);
    push_beat(CMD_COMPUTE, 0, 0);
    for (int i = 0; i < 5; i++) push_beat(CMD_READ, 0, i);
    wait_idle();
    // The open row refers past the loaded nodes once closed.
    push_beat(CMD_CLOSE, 0, 0);
    push_beat(CMD_COMPUTE, 0, 0);
    push_beat(CMD_READ, 0, 4);
    wait_idle();
    for (int m = 1; m < 4; m++) begin
      write_reg(REG_REVERSE, m[0]);
      write_reg(REG_PRESERVE, m[1]);
      push_beat(CMD_CLOSE, 0, 0);
      push_beat(CMD_COMPUTE, 0, 0);
      for (int i = 0; i < 7; i++) push_beat(CMD_READ, 0, i);
      wait_idle();
    end

    // Random rows with computes and read bursts, modes changed now and then.
    while (n_items < 680) begin
      k = $urandom_range(0, 99);
      if (k < 65) begin
        repeat ($urandom_range(0, 4))
          push_beat(CMD_ADD, ($urandom_range(0, 49) == 0) ? $urandom_range(0, plan_nodes + 40)
                                                          : $urandom_range(0, plan_nodes + 1), 0);
        if ($urandom_range(0, 5) != 0) push_beat(CMD_CLOSE, 0, 0);
      end else if (k < 75) begin
        push_beat(CMD_COMPUTE, 0, 0);
        read_burst($urandom_range(3, 8));
      end else if (k < 90) begin
        read_burst($urandom_range(1, 4));
      end else if (k < 93) begin
        wait_idle();
        write_reg(REG_REVERSE, 1'($urandom_range(0, 1)));
        write_reg(REG_PRESERVE, 1'($urandom_range(0, 1)));
      end else begin
        push_beat(cmd_t'($urandom_range(0, 3)), $urandom_range(0, 1023), $urandom_range(0, 1023));
      end
    end
    wait_idle();

    // Closing stretch with no idling on either side.
    quiet = 1;
    write_reg(REG_REVERSE, 1'b1);
    write_reg(REG_PRESERVE, 1'b1);
    repeat (50) begin
      push_beat(CMD_ADD, $urandom_range(0, plan_nodes + 1), 0);
      if ($urandom_range(0, 2) == 0) push_beat(CMD_CLOSE, 0, 0);
    end
    push_beat(CMD_CLOSE, 0, 0);
    push_beat(CMD_CLOSE, 0, 0);
    push_beat(CMD_COMPUTE, 0, 0);
    read_burst(20);
    push_beat(CMD_READ, 0, 1023);
    wait_idle();
    write_reg(REG_PRESERVE, 1'b0);
    write_reg(REG_REVERSE, 1'b0);
    push_beat(CMD_COMPUTE, 0, 0);
    read_burst(20);
    push_beat(CMD_READ, 0, 1023);
    wait_idle();
    repeat (30) @(posedge clk);

    $display("Sent %0d request beats (%0d computes, %0d reads) in all four table modes,",
             n_items, n_computes, n_reads);
    $display("checked %0d response beats, graph grown to %0d nodes and %0d edges.",
             n_results, n_nodes, n_edges);
    if (errors == 0 && expected_rsp.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
